### rtl/tst_pkg.sv
// shared types and constants of the tunnel session table
package tst_pkg;

    localparam int OWNER_W = 7;

    localparam logic [2:0] OP_ASSIGN    = 3'd0;
    localparam logic [2:0] OP_KEEPALIVE = 3'd1;
    localparam logic [2:0] OP_RELEASE   = 3'd2;
    localparam logic [2:0] OP_ROUTE     = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;

    localparam logic [2:0] KIND_ASSIGN    = 3'd0;
    localparam logic [2:0] KIND_KEEPALIVE = 3'd1;
    localparam logic [2:0] KIND_RELEASE   = 3'd2;
    localparam logic [2:0] KIND_ROUTE     = 3'd3;
    localparam logic [2:0] KIND_EVENT     = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE = 3'd5;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_POOL_FULL = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_BOUND     = 2'd3;

    localparam logic [1:0] CFG_SUBNET_PREFIX    = 2'd0;
    localparam logic [1:0] CFG_KEEPALIVE_PERIOD = 2'd1;
    localparam logic [1:0] CFG_IDLE_LIMIT       = 2'd2;

    localparam logic [23:0] SUBNET_PREFIX_RESET    = 24'd854016;
    localparam logic [7:0]  KEEPALIVE_PERIOD_RESET = 8'd20;
    localparam logic [7:0]  IDLE_LIMIT_RESET       = 8'd60;

    localparam int         FIRST_SLOT = 2;
    localparam logic [5:0] MAX_EVENTS = 6'd62;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [7:0]         countdown;
        logic [7:0]         idle_age;
    } slot_ent_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HREAD,
        ST_VERIFY,
        ST_SCAN,
        ST_ROUTE,
        ST_TK_SCAN,
        ST_TK_MOD,
        ST_TK_DONE
    } state_t;

endpackage

### rtl/tst_ram.sv
// generic simple dual port ram with registered read
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/tunnel_session_table.sv
// tunnel session table: session slots, handle lookup, routing and keepalive ageing
//
// One op per transaction on the s_ channel (op, handle, dest_addr). Results leave on
// the m_ channel, one transaction each, m_last marking the final result of an op.
// Configuration registers are written over cfg_valid/cfg_index/cfg_data, always ready;
// write them only while the table is idle, which the block itself does not enforce.
// Sequence of each op, behind the registered reads of the slot and handle rams:
//   route: ST_ROUTE; keepalive, release, rejected assign: ST_HREAD, ST_VERIFY;
//   assign: ST_HREAD, ST_VERIFY, then ST_SCAN over occupied slots from slot 2 up;
//   tick: ST_TK_SCAN per slot, ST_TK_MOD per live slot, then the tick-done result.
// One op is in flight at a time; s_ready rises again once the last result sits in
// the output register, so the next op is taken while that result waits.
// A stalled m_ready holds the output register and the sequencer waits on it.
// Reset clears the live and bound bits and loads the register defaults; no clearing
// pass runs, the table is usable in the cycle after reset. Slot ram contents are only
// trusted behind a live bit, handle ram contents only behind a bound bit.
module tunnel_session_table #(
    parameter int POOL_SLOTS   = 64,
    parameter int HANDLE_COUNT = 128
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [6:0]  s_handle,
    input  logic [31:0] s_dest_addr,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [1:0]  m_status,
    output logic [6:0]  m_handle_out,
    output logic [5:0]  m_host,
    output logic        m_send_keepalive,
    output logic        m_timed_out,
    output logic        m_last
);

    localparam int SW = $clog2(POOL_SLOTS);
    localparam int HW = $clog2(HANDLE_COUNT);
    localparam logic [SW-1:0] LAST_SLOT  = SW'(POOL_SLOTS - 1);
    localparam logic [SW-1:0] FIRST_SLOT = SW'(tst_pkg::FIRST_SLOT);

    tst_pkg::state_t state_reg, state_next;

    logic [2:0]              op_reg, op_next;
    logic [6:0]              h_reg, h_next;
    logic                    hok_reg, hok_next;
    logic                    match_reg, match_next;
    logic [SW-1:0]           slot_reg, slot_next;
    logic [SW-1:0]           idx_reg, idx_next;
    logic [5:0]              evcnt_reg, evcnt_next;
    logic [POOL_SLOTS-1:0]   live_reg;
    logic [HANDLE_COUNT-1:0] hbound_reg;
    logic [23:0]             subnet_reg;
    logic [7:0]              period_reg;
    logic [7:0]              limit_reg;

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [1:0]  status_reg;
    logic [6:0]  handle_out_reg;
    logic [5:0]  host_reg;
    logic        ka_reg;
    logic        to_reg;
    logic        last_reg;

    logic        emit;
    logic [2:0]  e_kind;
    logic [1:0]  e_status;
    logic [6:0]  e_handle;
    logic [5:0]  e_host;
    logic        e_ka;
    logic        e_to;
    logic        e_last;

    logic                live_wr_en;
    logic                live_wr_val;
    logic [SW-1:0]       live_wr_idx;

    logic                hb_wr_en;
    logic                hb_wr_val;
    logic [HW-1:0]       hb_wr_idx;

    logic                slot_wr_en;
    logic [SW-1:0]       slot_wr_addr;
    tst_pkg::slot_ent_t  slot_wr_data;
    logic                slot_rd_en;
    logic [SW-1:0]       slot_rd_addr;
    tst_pkg::slot_ent_t  ent;

    logic                hnd_wr_en;
    logic                hnd_rd_en;
    logic [HW-1:0]       hnd_rd_addr;
    logic [SW-1:0]       hnd_rd_data;

    logic        out_free;
    logic        accept;
    logic        hok_in;
    logic        bound;
    logic        idx_last;
    logic [7:0]  cd_dec;
    logic        tk_ka;
    logic [7:0]  cd_new;
    logic [7:0]  age_inc;
    logic        tk_to;
    logic        report;

    tst_ram #(
        .WIDTH ($bits(tst_pkg::slot_ent_t)),
        .DEPTH (POOL_SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (ent)
    );

    tst_ram #(
        .WIDTH (SW),
        .DEPTH (HANDLE_COUNT)
    ) u_handle_ram (
        .aclk    (aclk),
        .wr_en   (hnd_wr_en),
        .wr_addr (HW'(h_reg)),
        .wr_data (idx_reg),
        .rd_en   (hnd_rd_en),
        .rd_addr (hnd_rd_addr),
        .rd_data (hnd_rd_data)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == tst_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;
    assign hok_in    = 32'(s_handle) < HANDLE_COUNT;
    assign bound     = hok_reg && hbound_reg[HW'(h_reg)];
    assign idx_last  = (idx_reg == LAST_SLOT);

    assign cd_dec  = ent.countdown - 8'd1;
    assign tk_ka   = (cd_dec == 8'd0);
    assign cd_new  = tk_ka ? period_reg : cd_dec;
    assign age_inc = (ent.idle_age == 8'hFF) ? 8'hFF : ent.idle_age + 8'd1;
    assign tk_to   = (age_inc > limit_reg);
    assign report  = (tk_ka || tk_to) && (evcnt_reg < tst_pkg::MAX_EVENTS);

    assign hnd_rd_en   = accept;
    assign hnd_rd_addr = HW'(s_handle);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_op inside {tst_pkg::OP_ASSIGN, tst_pkg::OP_KEEPALIVE,
                                     tst_pkg::OP_RELEASE}) begin
                        state_next = tst_pkg::ST_HREAD;
                    end else if (s_op == tst_pkg::OP_ROUTE) begin
                        state_next = tst_pkg::ST_ROUTE;
                    end else if (s_op == tst_pkg::OP_TICK) begin
                        state_next = tst_pkg::ST_TK_SCAN;
                    end
                end
            end
            tst_pkg::ST_HREAD: begin
                state_next = tst_pkg::ST_VERIFY;
            end
            tst_pkg::ST_VERIFY: begin
                if (op_reg == tst_pkg::OP_ASSIGN && hok_reg && !bound) begin
                    state_next = tst_pkg::ST_SCAN;
                end else if (out_free) begin
                    state_next = tst_pkg::ST_IDLE;
                end
            end
            tst_pkg::ST_SCAN: begin
                if (out_free && (!live_reg[idx_reg] || idx_last)) begin
                    state_next = tst_pkg::ST_IDLE;
                end
            end
            tst_pkg::ST_ROUTE: begin
                if (out_free) begin
                    state_next = tst_pkg::ST_IDLE;
                end
            end
            tst_pkg::ST_TK_SCAN: begin
                if (live_reg[idx_reg]) begin
                    state_next = tst_pkg::ST_TK_MOD;
                end else if (idx_last) begin
                    state_next = tst_pkg::ST_TK_DONE;
                end
            end
            tst_pkg::ST_TK_MOD: begin
                if (!report || out_free) begin
                    state_next = idx_last ? tst_pkg::ST_TK_DONE : tst_pkg::ST_TK_SCAN;
                end
            end
            tst_pkg::ST_TK_DONE: begin
                if (out_free) begin
                    state_next = tst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tst_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control and results
    always_comb begin
        op_next      = op_reg;
        h_next       = h_reg;
        hok_next     = hok_reg;
        match_next   = match_reg;
        slot_next    = slot_reg;
        idx_next     = idx_reg;
        evcnt_next   = evcnt_reg;

        emit         = 1'b0;
        e_kind       = op_reg;
        e_status     = tst_pkg::STAT_OK;
        e_handle     = h_reg;
        e_host       = 6'd0;
        e_ka         = 1'b0;
        e_to         = 1'b0;
        e_last       = 1'b1;

        live_wr_en   = 1'b0;
        live_wr_val  = 1'b0;
        live_wr_idx  = idx_reg;

        hb_wr_en     = 1'b0;
        hb_wr_val    = 1'b0;
        hb_wr_idx    = HW'(h_reg);

        slot_wr_en   = 1'b0;
        slot_wr_addr = idx_reg;
        slot_wr_data = ent;
        slot_rd_en   = 1'b0;
        slot_rd_addr = idx_reg;
        hnd_wr_en    = 1'b0;

        case (state_reg)
            tst_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next      = s_op;
                    h_next       = s_handle;
                    hok_next     = hok_in;
                    match_next   = (s_dest_addr[31:8] == subnet_reg) &&
                                   ({1'b0, s_dest_addr[7:0]} < 9'(POOL_SLOTS));
                    slot_next    = SW'(s_dest_addr[7:0]);
                    idx_next     = '0;
                    evcnt_next   = '0;
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = SW'(s_dest_addr[7:0]);
                end
            end
            tst_pkg::ST_HREAD: begin
                slot_next    = hnd_rd_data;
                slot_rd_en   = 1'b1;
                slot_rd_addr = hnd_rd_data;
            end
            tst_pkg::ST_VERIFY: begin
                case (op_reg)
                    tst_pkg::OP_ASSIGN: begin
                        if (!hok_reg) begin
                            emit     = out_free;
                            e_status = tst_pkg::STAT_NOT_FOUND;
                        end else if (bound) begin
                            emit     = out_free;
                            e_status = tst_pkg::STAT_BOUND;
                            e_host   = 6'(slot_reg);
                        end else begin
                            idx_next = FIRST_SLOT;
                        end
                    end
                    tst_pkg::OP_KEEPALIVE: begin
                        emit = out_free;
                        if (bound) begin
                            e_host                = 6'(slot_reg);
                            slot_wr_en            = out_free;
                            slot_wr_addr          = slot_reg;
                            slot_wr_data.idle_age = 8'd0;
                        end else begin
                            e_status = tst_pkg::STAT_NOT_FOUND;
                        end
                    end
                    tst_pkg::OP_RELEASE: begin
                        emit = out_free;
                        if (bound) begin
                            e_host      = 6'(slot_reg);
                            live_wr_en  = out_free;
                            live_wr_idx = slot_reg;
                            hb_wr_en    = out_free;
                        end else begin
                            e_status = tst_pkg::STAT_NOT_FOUND;
                        end
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
            end
            tst_pkg::ST_SCAN: begin
                e_kind = tst_pkg::KIND_ASSIGN;
                if (!live_reg[idx_reg]) begin
                    emit                   = out_free;
                    e_host                 = 6'(idx_reg);
                    slot_wr_en             = out_free;
                    slot_wr_data.owner     = h_reg;
                    slot_wr_data.countdown = period_reg;
                    slot_wr_data.idle_age  = 8'd0;
                    hnd_wr_en              = out_free;
                    live_wr_en             = out_free;
                    live_wr_val            = 1'b1;
                    hb_wr_en               = out_free;
                    hb_wr_val              = 1'b1;
                end else if (idx_last) begin
                    emit     = out_free;
                    e_status = tst_pkg::STAT_POOL_FULL;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            tst_pkg::ST_ROUTE: begin
                emit   = out_free;
                e_kind = tst_pkg::KIND_ROUTE;
                if (match_reg && live_reg[slot_reg]) begin
                    e_handle = ent.owner;
                    e_host   = 6'(slot_reg);
                end else begin
                    e_status = tst_pkg::STAT_NOT_FOUND;
                    e_handle = 7'd0;
                end
            end
            tst_pkg::ST_TK_SCAN: begin
                if (live_reg[idx_reg]) begin
                    slot_rd_en = 1'b1;
                end else if (!idx_last) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            tst_pkg::ST_TK_MOD: begin
                e_kind   = tst_pkg::KIND_EVENT;
                e_handle = ent.owner;
                e_host   = 6'(idx_reg);
                e_ka     = tk_ka;
                e_to     = tk_to;
                e_last   = 1'b0;
                if (!report || out_free) begin
                    slot_wr_en             = 1'b1;
                    slot_wr_data.countdown = cd_new;
                    slot_wr_data.idle_age  = age_inc;
                    live_wr_en             = tk_to;
                    hb_wr_en               = tk_to;
                    hb_wr_idx              = HW'(ent.owner);
                    emit                   = report;
                    if (report) begin
                        evcnt_next = evcnt_reg + 6'd1;
                    end
                    if (!idx_last) begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            tst_pkg::ST_TK_DONE: begin
                emit     = out_free;
                e_kind   = tst_pkg::KIND_TICK_DONE;
                e_handle = 7'd0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tst_pkg::ST_IDLE;
            live_reg      <= '0;
            hbound_reg    <= '0;
            out_valid_reg <= 1'b0;
            subnet_reg    <= tst_pkg::SUBNET_PREFIX_RESET;
            period_reg    <= tst_pkg::KEEPALIVE_PERIOD_RESET;
            limit_reg     <= tst_pkg::IDLE_LIMIT_RESET;
        end else begin
            state_reg <= state_next;
            if (live_wr_en) begin
                live_reg[live_wr_idx] <= live_wr_val;
            end
            if (hb_wr_en) begin
                hbound_reg[hb_wr_idx] <= hb_wr_val;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    tst_pkg::CFG_SUBNET_PREFIX:    subnet_reg <= cfg_data;
                    tst_pkg::CFG_KEEPALIVE_PERIOD: period_reg <= cfg_data[7:0];
                    tst_pkg::CFG_IDLE_LIMIT:       limit_reg  <= cfg_data[7:0];
                    default: begin
                        subnet_reg <= subnet_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        h_reg     <= h_next;
        hok_reg   <= hok_next;
        match_reg <= match_next;
        slot_reg  <= slot_next;
        idx_reg   <= idx_next;
        evcnt_reg <= evcnt_next;
        if (emit) begin
            kind_reg       <= e_kind;
            status_reg     <= e_status;
            handle_out_reg <= e_handle;
            host_reg       <= e_host;
            ka_reg         <= e_ka;
            to_reg         <= e_to;
            last_reg       <= e_last;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = kind_reg;
    assign m_status         = status_reg;
    assign m_handle_out     = handle_out_reg;
    assign m_host           = host_reg;
    assign m_send_keepalive = ka_reg;
    assign m_timed_out      = to_reg;
    assign m_last           = last_reg;

endmodule

### rtl/tst_checker.sv
// port-level checks of the tunnel session table, bound to the top level
module tst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_kind,
    input logic [1:0]  m_status,
    input logic [6:0]  m_handle_out,
    input logic [5:0]  m_host,
    input logic        m_send_keepalive,
    input logic        m_timed_out,
    input logic        m_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_status) &&
            $stable(m_handle_out) && $stable(m_host) && $stable(m_last))
        else $error("result changed while stalled");

    // no new op while a tick still has results to give
    a_no_accept_mid_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("op accepted before last result");

    // slot events carry a flag and are never last
    a_event_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == tst_pkg::KIND_EVENT |->
            (m_send_keepalive || m_timed_out) && !m_last)
        else $error("malformed slot event");

    // every other result is last and flagless
    a_single_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != tst_pkg::KIND_EVENT |->
            m_last && !m_send_keepalive && !m_timed_out)
        else $error("malformed single result");

    // a failed route names no session
    a_route_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == tst_pkg::KIND_ROUTE && m_status == tst_pkg::STAT_NOT_FOUND
            |-> m_handle_out == 7'd0 && m_host == 6'd0)
        else $error("route miss with session data");

endmodule

bind tunnel_session_table tst_checker u_tst_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_kind           (m_kind),
    .m_status         (m_status),
    .m_handle_out     (m_handle_out),
    .m_host           (m_host),
    .m_send_keepalive (m_send_keepalive),
    .m_timed_out      (m_timed_out),
    .m_last           (m_last)
);
